[src/ordered_clamp_composition_tree_top_assert.svh]
// Assertion macros for the RTL of the clamp composition tree.
`ifndef ORDERED_CLAMP_COMPOSITION_TREE_TOP_ASSERT_SVH
`define ORDERED_CLAMP_COMPOSITION_TREE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OCCT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OCCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/occt_pkg.sv]
`timescale 1ns / 1ps

package occt_pkg;

    localparam int DefSlots      = 1024;
    localparam int DefHeightBits = 20;

    localparam int CmdW   = 2;
    localparam int SlotW  = 10;
    localparam int LevelW = 20;
    localparam int OutW   = 20;

    typedef enum logic [CmdW-1:0] {
        CMD_RAISE = 2'd0,
        CMD_LOWER = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

endpackage

[src/occt_combine.sv]
`timescale 1ns / 1ps

module occt_combine #(
    parameter int HEIGHT_BITS = occt_pkg::DefHeightBits
) (
    input  logic [HEIGHT_BITS-1:0] i_first_lo,
    input  logic [HEIGHT_BITS-1:0] i_first_hi,
    input  logic [HEIGHT_BITS-1:0] i_second_lo,
    input  logic [HEIGHT_BITS-1:0] i_second_hi,
    output logic [HEIGHT_BITS-1:0] o_lo,
    output logic [HEIGHT_BITS-1:0] o_hi
);

    import occt_pkg::*;

    // The first interval is applied before the second one.
    always_comb begin
        priority if (i_first_hi < i_second_lo) begin
            o_lo = i_second_lo;
            o_hi = i_second_lo;
        end else if (i_second_hi < i_first_lo) begin
            o_lo = i_second_hi;
            o_hi = i_second_hi;
        end else begin
            o_lo = (i_first_lo > i_second_lo) ? i_first_lo : i_second_lo;
            o_hi = (i_first_hi < i_second_hi) ? i_first_hi : i_second_hi;
        end
    end

endmodule

[src/ordered_clamp_composition_tree_top.sv]
// Update (raise, lower, clear) on a valid slot: busy while the walk recombines one
// tree level per cycle from the leaf to the root; the result strobe comes on the
// cycle busy drops, and no new beat is taken while busy.
// Query or out-of-range slot: result strobe on the cycle after the beat, one per cycle.
// Synchronous active-low reset, then a clearing pass over every tree node with busy high.
// The receiver cannot stall results.
`timescale 1ns / 1ps

module ordered_clamp_composition_tree_top #(
    parameter int SLOTS       = occt_pkg::DefSlots,
    parameter int HEIGHT_BITS = occt_pkg::DefHeightBits
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  occt_pkg::t_cmd              i_cmd,
    input  logic [occt_pkg::SlotW-1:0]  i_slot,
    input  logic [occt_pkg::LevelW-1:0] i_level,
    output logic                        o_done,
    output logic [occt_pkg::OutW-1:0]   o_wall_height,
    output logic [occt_pkg::OutW-1:0]   o_composed_low,
    output logic [occt_pkg::OutW-1:0]   o_composed_high
);

    import occt_pkg::*;

    localparam int LW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW    = LW + 1;
    localparam int NODES = 2 ** AW;
    localparam int HB    = HEIGHT_BITS;
    localparam logic [HB-1:0] HMax = {HB{1'b1}};
    localparam logic [AW-1:0] RootAddr = AW'(1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_pos;
    logic [AW-1:0]    r_clr_addr;
    logic [HB-1:0]    r_cur_lo;
    logic [HB-1:0]    r_cur_hi;
    logic [HB-1:0]    r_root_lo;
    logic [HB-1:0]    r_root_hi;
    logic [2*HB-1:0]  r_sib;
    logic             r_done;
    logic [OutW-1:0]  r_wall;
    logic [OutW-1:0]  r_low;
    logic [OutW-1:0]  r_high;

    logic [2*HB-1:0]  mem [NODES];

    logic             accept;
    logic             slot_ok;
    logic             do_update;
    logic [SlotW+LW-1:0]   slot_wide;
    logic [LevelW+HB-1:0]  level_wide;
    logic [HB-1:0]    level_m;
    logic [HB-1:0]    leaf_lo;
    logic [HB-1:0]    leaf_hi;
    logic [AW-1:0]    leaf_pos;
    logic [AW-1:0]    parent;
    logic [HB-1:0]    sib_lo;
    logic [HB-1:0]    sib_hi;
    logic [HB-1:0]    first_lo;
    logic [HB-1:0]    first_hi;
    logic [HB-1:0]    second_lo;
    logic [HB-1:0]    second_hi;
    logic [HB-1:0]    comb_lo;
    logic [HB-1:0]    comb_hi;
    logic [OutW+HB-1:0] root_lo_wide;
    logic [OutW+HB-1:0] root_hi_wide;
    logic [OutW+HB-1:0] comb_lo_wide;
    logic [OutW+HB-1:0] comb_hi_wide;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [2*HB-1:0]  mem_wdata;
    logic [AW-1:0]    mem_raddr;

    assign busy      = (r_state != ST_IDLE);
    assign accept    = start && !busy;
    assign slot_ok   = (32'(i_slot) < SLOTS);
    assign do_update = (i_cmd != CMD_QUERY) && slot_ok;

    assign slot_wide  = {{LW{1'b0}}, i_slot};
    assign level_wide = {{HB{1'b0}}, i_level};
    assign level_m    = level_wide[HB-1:0];
    assign leaf_pos   = {1'b1, slot_wide[LW-1:0]};

    always_comb begin
        unique case (i_cmd)
            CMD_RAISE: begin
                leaf_lo = level_m;
                leaf_hi = HMax;
            end
            CMD_LOWER: begin
                leaf_lo = '0;
                leaf_hi = level_m;
            end
            default: begin
                leaf_lo = '0;
                leaf_hi = HMax;
            end
        endcase
    end

    assign parent = {1'b0, r_pos[AW-1:1]};
    assign sib_lo = r_sib[HB-1:0];
    assign sib_hi = r_sib[2*HB-1:HB];

    always_comb begin
        if (r_pos[0]) begin
            first_lo  = sib_lo;
            first_hi  = sib_hi;
            second_lo = r_cur_lo;
            second_hi = r_cur_hi;
        end else begin
            first_lo  = r_cur_lo;
            first_hi  = r_cur_hi;
            second_lo = sib_lo;
            second_hi = sib_hi;
        end
    end

    occt_combine #(
        .HEIGHT_BITS (HB)
    ) u_combine (
        .i_first_lo  (first_lo),
        .i_first_hi  (first_hi),
        .i_second_lo (second_lo),
        .i_second_hi (second_hi),
        .o_lo        (comb_lo),
        .o_hi        (comb_hi)
    );

    assign root_lo_wide = {{OutW{1'b0}}, r_root_lo};
    assign root_hi_wide = {{OutW{1'b0}}, r_root_hi};
    assign comb_lo_wide = {{OutW{1'b0}}, comb_lo};
    assign comb_hi_wide = {{OutW{1'b0}}, comb_hi};

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = {HMax, {HB{1'b0}}};
        mem_raddr = leaf_pos ^ AW'(1);
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                mem_we    = accept && do_update;
                mem_waddr = leaf_pos;
                mem_wdata = {leaf_hi, leaf_lo};
            end
            ST_WALK: begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = {comb_hi, comb_lo};
                mem_raddr = parent ^ AW'(1);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_sib <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
            r_root_lo  <= '0;
            r_root_hi  <= HMax;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_done     <= 1'b0;
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == {AW{1'b1}}) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    r_done <= accept && !do_update;
                    if (accept) begin
                        if (do_update) begin
                            r_pos    <= leaf_pos;
                            r_cur_lo <= leaf_lo;
                            r_cur_hi <= leaf_hi;
                            r_state  <= ST_WALK;
                        end else begin
                            r_wall <= root_lo_wide[OutW-1:0];
                            r_low  <= root_lo_wide[OutW-1:0];
                            r_high <= root_hi_wide[OutW-1:0];
                        end
                    end
                end
                ST_WALK: begin
                    r_done   <= (parent == RootAddr);
                    r_cur_lo <= comb_lo;
                    r_cur_hi <= comb_hi;
                    r_pos    <= parent;
                    if (parent == RootAddr) begin
                        r_root_lo <= comb_lo;
                        r_root_hi <= comb_hi;
                        r_wall    <= comb_lo_wide[OutW-1:0];
                        r_low     <= comb_lo_wide[OutW-1:0];
                        r_high    <= comb_hi_wide[OutW-1:0];
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done          = r_done;
    assign o_wall_height   = r_wall;
    assign o_composed_low  = r_low;
    assign o_composed_high = r_high;

`include "ordered_clamp_composition_tree_top_assert.svh"

    `OCCT_ASSERT_NEXT(a_beat_progress, i_clk, i_rst_n, accept, busy || o_done, "beat lost")
    `OCCT_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result while busy")
    `OCCT_ASSERT_SAME(a_wall_low, i_clk, i_rst_n, o_done, o_wall_height == o_composed_low, "wall mismatch")
    `OCCT_ASSERT_NEXT(a_query_fast, i_clk, i_rst_n, accept && (i_cmd == CMD_QUERY), o_done && !busy, "query slow")

endmodule

[verif/ordered_clamp_composition_tree_top_test.sv]
`timescale 1ns / 1ps

module ordered_clamp_composition_tree_top_test;

    import occt_pkg::*;

    localparam int Slots       = DefSlots;
    localparam int HeightBits  = DefHeightBits;
    localparam int LeafBase    = 1 << $clog2(Slots);
    localparam int NodeCount   = 2 * LeafBase;
    localparam int ItemCount   = 500;
    localparam int DrainCycles = 16;
    localparam int CycleLimit  = 400000;
    localparam logic [HeightBits-1:0] HeightMax = {HeightBits{1'b1}};

    typedef struct packed {
        logic [HeightBits-1:0] lo;
        logic [HeightBits-1:0] hi;
    } t_clamp_span;

    typedef struct packed {
        logic [OutW-1:0] wall;
        logic [OutW-1:0] low;
        logic [OutW-1:0] high;
    } t_wall_report;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    t_cmd              i_cmd   = CMD_QUERY;
    logic [SlotW-1:0]  i_slot  = '0;
    logic [LevelW-1:0] i_level = '0;
    logic              o_done;
    logic [OutW-1:0]   o_wall_height;
    logic [OutW-1:0]   o_composed_low;
    logic [OutW-1:0]   o_composed_high;

    t_clamp_span  clamp_nodes [NodeCount];
    t_wall_report expected_walls [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    bit           idle_burst     = 1'b0;

    ordered_clamp_composition_tree_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_slot          (i_slot),
        .i_level         (i_level),
        .o_done          (o_done),
        .o_wall_height   (o_wall_height),
        .o_composed_low  (o_composed_low),
        .o_composed_high (o_composed_high)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_clamp_span compose_pair(t_clamp_span first, t_clamp_span second);
        t_clamp_span r;
        if (first.hi < second.lo) begin
            r.lo = second.lo;
            r.hi = second.lo;
        end else if (second.hi < first.lo) begin
            r.lo = second.hi;
            r.hi = second.hi;
        end else begin
            r.lo = (first.lo > second.lo) ? first.lo : second.lo;
            r.hi = (first.hi < second.hi) ? first.hi : second.hi;
        end
        return r;
    endfunction

    function automatic t_wall_report predict_wall(t_cmd cmd, logic [SlotW-1:0] slot,
                                                  logic [LevelW-1:0] level);
        int           pos;
        logic [HeightBits-1:0] height;
        t_clamp_span  ground;
        t_clamp_span  wall;
        t_wall_report rep;
        height = level[HeightBits-1:0];
        if (cmd != CMD_QUERY && int'(slot) < Slots) begin
            pos = LeafBase + int'(slot);
            case (cmd)
                CMD_RAISE: clamp_nodes[pos] = '{lo: height, hi: HeightMax};
                CMD_LOWER: clamp_nodes[pos] = '{lo: '0, hi: height};
                default:   clamp_nodes[pos] = '{lo: '0, hi: HeightMax};
            endcase
            pos = pos >> 1;
            while (pos >= 1) begin
                clamp_nodes[pos] = compose_pair(clamp_nodes[2 * pos], clamp_nodes[2 * pos + 1]);
                pos = pos >> 1;
            end
        end
        ground   = '{lo: '0, hi: '0};
        wall     = compose_pair(ground, clamp_nodes[1]);
        rep.wall = OutW'(wall.lo);
        rep.low  = OutW'(clamp_nodes[1].lo);
        rep.high = OutW'(clamp_nodes[1].hi);
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_wall_report exp_rep;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (expected_walls.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result beat: wall %0d low %0d high %0d",
                                 o_wall_height, o_composed_low, o_composed_high);
                    mismatch_count++;
                end else begin
                    exp_rep = expected_walls.pop_front();
                    if (o_wall_height !== exp_rep.wall || o_composed_low !== exp_rep.low
                        || o_composed_high !== exp_rep.high) begin
                        if (mismatch_count < 10)
                            $display("mismatch: expected wall %0d low %0d high %0d, %s %0d %0d %0d",
                                     exp_rep.wall, exp_rep.low, exp_rep.high,
                                     "got", o_wall_height, o_composed_low, o_composed_high);
                        mismatch_count++;
                    end
                end
            end
            if (start && busy === 1'b0)
                expected_walls.insert(expected_walls.size(),
                                      predict_wall(i_cmd, i_slot, i_level));
        end
    end

    task automatic send_beat(t_cmd cmd, logic [SlotW-1:0] slot, logic [LevelW-1:0] level);
        int gap;
        i_cmd   <= cmd;
        i_slot  <= slot;
        i_level <= level;
        start   <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        gap = idle_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_walls();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_walls.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_identity();
        send_beat(CMD_QUERY, '0, '0);
        send_beat(CMD_QUERY, '1, '1);
    endtask

    task automatic test_field_extremes();
        send_beat(CMD_RAISE, '0, '0);
        send_beat(CMD_RAISE, '0, '1);
        send_beat(CMD_LOWER, '1, '1);
        send_beat(CMD_LOWER, '1, '0);
        send_beat(CMD_CLEAR, '0, '1);
        send_beat(CMD_CLEAR, '1, '0);
        send_beat(CMD_QUERY, 10'd512, 20'h55555);
    endtask

    task automatic test_disjoint_collapse();
        send_beat(CMD_RAISE, 10'd5, 20'd1000);
        send_beat(CMD_LOWER, 10'd6, 20'd500);
        send_beat(CMD_LOWER, 10'd3, 20'd200);
        send_beat(CMD_RAISE, 10'd4, 20'd800);
        send_beat(CMD_CLEAR, 10'd3, 20'd0);
        send_beat(CMD_CLEAR, 10'd4, 20'd0);
        send_beat(CMD_CLEAR, 10'd5, 20'd0);
        send_beat(CMD_CLEAR, 10'd6, 20'd0);
    endtask

    task automatic test_overlap_and_query();
        send_beat(CMD_RAISE, 10'd10, 20'd100);
        send_beat(CMD_LOWER, 10'd11, 20'd300);
        send_beat(CMD_QUERY, 10'd11, 20'hAAAAA);
        send_beat(CMD_CLEAR, 10'd10, 20'd0);
        send_beat(CMD_CLEAR, 10'd11, 20'd0);
    endtask

    task automatic test_random_updates();
        int               n;
        int               pick;
        t_cmd             cmd;
        logic [SlotW-1:0] slot;
        logic [LevelW-1:0] level;
        for (n = 0; n < ItemCount; n++) begin
            if (n % 50 == 0)
                idle_burst = ($urandom_range(0, 3) == 0);
            if (n % 120 == 119)
                drain_walls();
            pick = $urandom_range(0, 99);
            if (pick < 35)
                cmd = CMD_RAISE;
            else if (pick < 70)
                cmd = CMD_LOWER;
            else if (pick < 85)
                cmd = CMD_CLEAR;
            else
                cmd = CMD_QUERY;
            case ($urandom_range(0, 2))
                0:       slot = SlotW'($urandom_range(0, 7));
                1:       slot = SlotW'($urandom_range(Slots - 8, Slots - 1));
                default: slot = SlotW'($urandom_range(0, Slots - 1));
            endcase
            case ($urandom_range(0, 3))
                0:       level = LevelW'($urandom_range(0, 15));
                1:       level = LevelW'(HeightMax) - LevelW'($urandom_range(0, 15));
                2:       level = LevelW'($urandom_range(500000, 550000));
                default: level = LevelW'($urandom());
            endcase
            send_beat(cmd, slot, level);
        end
    endtask

    initial begin
        for (int k = 0; k < NodeCount; k++)
            clamp_nodes[k] = '{lo: '0, hi: HeightMax};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_identity();
        test_field_extremes();
        test_disjoint_collapse();
        test_overlap_and_query();
        drain_walls();
        test_random_updates();
        drain_walls();
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0 && expected_walls.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
